/* design/crt_pkg.sv */
// Package for the client registry table: widths, request and status codes,
// and the structs passed along the cell chain. No dependencies.
`default_nettype none

package crt_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 34;
  localparam int HANDLE_W  = 16;
  localparam int UID_W     = 6;
  localparam int NEXT_ID_W = 7;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int FIELD_W   = 6;   // result_index / result_user_id / entry_index

  // request codes
  localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND       = 2'd1;
  localparam logic [OP_W-1:0] OP_DISCONNECT = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REATTACHED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd6;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 3'd7;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_ADD,
    CMD_REATTACH,
    CMD_CLEAR
  } cmd_kind_t;

  // search token walking down the chain; carries the first hit
  typedef struct packed {
    logic             active;
    logic             hit;
    logic [IDX_W-1:0] index;
    logic             conn;
    logic [UID_W-1:0] uid;
  } probe_t;

  // update broadcast to all cells, taken by the addressed one
  typedef struct packed {
    cmd_kind_t           kind;
    logic [IDX_W-1:0]    index;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [UID_W-1:0]    uid;
  } cmd_t;

endpackage

`default_nettype wire

/* design/crt_cell.sv */
// One table entry: key, handle, connected mark, user id, valid.
// Passes the search token to its neighbor each cycle. Uses crt_pkg.
`default_nettype none

module crt_cell
  import crt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] cell_index,
  input  wire logic [KEY_W-1:0] key,
  input  wire cmd_t             cmd,
  input  wire probe_t           probe_in,
  output probe_t                probe_out
);

  logic                valid;
  logic                conn;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [UID_W-1:0]    uid_q;
  logic                sel;
  logic                match;
  probe_t              probe_next;

  assign sel   = (cmd.kind != CMD_NONE) && (cmd.index == cell_index);
  assign match = probe_in.active && !probe_in.hit && valid && (key_q == key);

  always_comb begin
    probe_next = probe_in;
    if (match) begin
      probe_next.hit   = 1'b1;
      probe_next.index = cell_index;
      probe_next.conn  = conn;
      probe_next.uid   = uid_q;
    end
  end

  // control bits and token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      conn      <= 1'b0;
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
      if (sel) begin
        case (cmd.kind)
          CMD_ADD: begin
            valid <= 1'b1;
            conn  <= 1'b1;
          end
          CMD_REATTACH: conn <= 1'b1;
          CMD_CLEAR:    conn <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (sel && cmd.kind == CMD_ADD) begin
      key_q    <= cmd.key;
      handle_q <= cmd.handle;
      uid_q    <= cmd.uid;
    end else if (sel && cmd.kind == CMD_REATTACH) begin
      handle_q <= cmd.handle;
    end
  end

endmodule

`default_nettype wire

/* design/crt_ctrl.sv */
// Request sequencer: takes a request, launches the search token, decides
// the status and the table update, holds the result register. Uses crt_pkg.
`default_nettype none

module crt_ctrl
  import crt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire logic [OP_W-1:0]     req_op,
  input  wire logic [KEY_W-1:0]    req_key,
  input  wire logic [HANDLE_W-1:0] req_handle,
  input  wire logic [FIELD_W-1:0]  req_idx,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output logic [STATUS_W-1:0]      res_status,
  output logic [FIELD_W-1:0]       res_index,
  output logic [FIELD_W-1:0]       res_uid,
  output logic [KEY_W-1:0]         search_key,
  output probe_t                   probe_head,
  input  wire probe_t              probe_tail,
  output cmd_t                     cmd
);

  localparam int CMP_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESPOND
  } state_t;

  state_t               state;
  logic [OP_W-1:0]      op_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [FIELD_W-1:0]   idx_q;
  logic                 launch;
  probe_t               hit_q;
  logic [CNT_W-1:0]     entry_count;
  logic [NEXT_ID_W-1:0] next_user_id;

  logic                 accept;
  logic                 fire;
  cmd_kind_t            kind;
  logic [IDX_W-1:0]     target;
  logic [STATUS_W-1:0]  status;
  logic [FIELD_W-1:0]   r_index;
  logic [FIELD_W-1:0]   r_uid;
  logic [UID_W-1:0]     new_uid;
  logic                 idx_ok;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign fire      = (state == S_RESPOND) && (!res_valid || res_ready);
  assign new_uid   = next_user_id[UID_W-1:0];
  assign idx_ok    = CMP_W'(idx_q) < CMP_W'(entry_count);

  always_comb begin
    probe_head        = '0;
    probe_head.active = launch;
  end

  // outcome of the request
  always_comb begin
    kind    = CMD_NONE;
    target  = '0;
    status  = ST_BAD_INDEX;
    r_index = '0;
    r_uid   = '0;
    case (op_q)
      OP_REGISTER: begin
        if (!hit_q.hit) begin
          if (entry_count == CNT_W'(ENTRIES)) begin
            status = ST_FULL;
          end else begin
            status  = ST_ADDED;
            kind    = CMD_ADD;
            target  = IDX_W'(entry_count);
            r_index = FIELD_W'(entry_count);
            r_uid   = FIELD_W'(new_uid);
          end
        end else if (hit_q.conn) begin
          status = ST_ALREADY;
        end else begin
          status  = ST_REATTACHED;
          kind    = CMD_REATTACH;
          target  = hit_q.index;
          r_index = FIELD_W'(hit_q.index);
          r_uid   = FIELD_W'(hit_q.uid);
        end
      end
      OP_FIND: begin
        if (hit_q.hit) begin
          status  = ST_FOUND;
          r_index = FIELD_W'(hit_q.index);
          r_uid   = FIELD_W'(hit_q.uid);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      OP_DISCONNECT: begin
        if (idx_ok) begin
          status = ST_CLEARED;
          kind   = CMD_CLEAR;
          target = IDX_W'(idx_q);
        end
      end
      default: status = ST_BAD_INDEX;
    endcase
  end

  always_comb begin
    cmd.kind   = fire ? kind : CMD_NONE;
    cmd.index  = target;
    cmd.key    = search_key;
    cmd.handle = handle_q;
    cmd.uid    = new_uid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launch       <= 1'b0;
      res_valid    <= 1'b0;
      entry_count  <= '0;
      next_user_id <= '0;
    end else begin
      launch <= accept && (req_op == OP_REGISTER || req_op == OP_FIND);
      if (fire) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q       <= req_op;
            search_key <= req_key;
            handle_q   <= req_handle;
            idx_q      <= req_idx;
            hit_q      <= '0;
            if (req_op == OP_REGISTER || req_op == OP_FIND) begin
              state <= S_SEARCH;
            end else begin
              state <= S_RESPOND;
            end
          end
        end
        S_SEARCH: begin
          if (probe_tail.active) begin
            hit_q <= probe_tail;
            state <= S_RESPOND;
          end
        end
        S_RESPOND: begin
          if (fire) begin
            res_status <= status;
            res_index  <= r_index;
            res_uid    <= r_uid;
            if (kind == CMD_ADD) begin
              entry_count  <= entry_count + CNT_W'(1);
              next_user_id <= next_user_id + NEXT_ID_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/client_registry_table_top.sv */
// Top level of the client registry table: request sequencer plus a chain
// of ENTRIES entry cells. Depends on crt_pkg, crt_ctrl, crt_cell.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  --------+-----+---------------------------------------------+------------------
//  s_*     | in  | phone_key[33:0] conn_handle[49:34]          | operation[1:0]
//          |     | entry_index[55:50]                          |
//  m_*     | out | result_index[5:0] result_user_id[11:6], 0s  | status[2:0]
//
// Register and find: the launch flag is registered, the search token steps
// through the chain one cell per cycle, the tail token is captured and the
// result register is loaded; the chain length sets the search time.
// Disconnect and undefined requests go straight to the result step.
// One request is in the block at a time; s_tready is high only when idle.
// A result waiting in the output register does not block the next
// transfer in; the block stalls only when a second result is ready first.
// rst is synchronous: clears connected marks, valid bits, entry count and
// next id. Stored keys, handles and ids are not cleared.
`default_nettype none

module client_registry_table_top
  import crt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // phone_key, conn_handle, entry_index
  input  wire logic [1:0]  s_tuser,   // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // result_index, result_user_id, zero pad
  output logic [2:0]       m_tuser    // status
);

  logic [KEY_W-1:0]   search_key;
  logic [FIELD_W-1:0] res_index;
  logic [FIELD_W-1:0] res_uid;
  cmd_t               cmd;
  probe_t             chain [ENTRIES+1];

  crt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req_op     (s_tuser),
    .req_key    (s_tdata[33:0]),
    .req_handle (s_tdata[49:34]),
    .req_idx    (s_tdata[55:50]),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_status (m_tuser),
    .res_index  (res_index),
    .res_uid    (res_uid),
    .search_key (search_key),
    .probe_head (chain[0]),
    .probe_tail (chain[ENTRIES]),
    .cmd        (cmd)
  );

  // cell i sees the token in the cycle after cell i-1; first match wins
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    crt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(i)),
      .key        (search_key),
      .cmd        (cmd),
      .probe_in   (chain[i]),
      .probe_out  (chain[i+1])
    );
  end

  assign m_tdata = {4'b0000, res_uid, res_index};

endmodule

`default_nettype wire

/* design/crt_checker.sv */
// Port-level checks for client_registry_table_top, bound to the top level.
// Uses crt_pkg for status codes.
`default_nettype none

module crt_checker
  import crt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("transfer accepted while busy");

  // only added, reattached and found carry index and id
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !(m_tuser == ST_ADDED || m_tuser == ST_REATTACHED ||
                  m_tuser == ST_FOUND) |-> m_tdata == 16'h0000)
    else $error("nonzero index or id on a status without entry");

  // padding stays clear
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:12] == 4'b0000)
    else $error("pad bits set");

  // a result appears only out of a busy cycle
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without a request in flight");

endmodule

bind client_registry_table_top crt_checker u_crt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
